// ===== design/bb3_pkg.sv =====
// types, constants and the rounding divide for the 3x3 box blur core
package bb3_pkg;

  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 12;
  localparam int ROW_W   = 17;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W   = 16;
  localparam int FRAME_WIDTH_W = 11;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  localparam int CREDIT_W   = 5;

  // reciprocals scaled by 2^16, exact over the sums that can reach them
  localparam int RECIP_SHIFT = 16;
  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;

  localparam logic [SUM_W-1:0] BIAS4 = 12'd2;
  localparam logic [SUM_W-1:0] BIAS6 = 12'd3;
  localparam logic [SUM_W-1:0] BIAS9 = 12'd4;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic last;
  } geom_t;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef struct packed {
    rgb_t pix;
    logic last;
  } out_item_t;

  // (2*sum + n) / (2*n) rounds half up, same as (sum + n/2) / n with n/2 floored
  function automatic logic [CHAN_W-1:0] div_round(logic [SUM_W-1:0] sum, div_t d);
    logic [SUM_W-1:0] x;
    logic [25:0] p;
    logic [CHAN_W-1:0] q;
    x = '0;
    p = '0;
    q = '0;
    case (d)
      DIV4: begin
        x = sum + BIAS4;
        q = x[9:2];
      end
      DIV6: begin
        x = sum + BIAS6;
        p = 26'(x) * 26'(RECIP6);
        q = p[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      end
      DIV9: begin
        x = sum + BIAS9;
        p = 26'(x) * 26'(RECIP9);
        q = p[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      end
      default: begin
        x = sum + BIAS4;
        q = x[9:2];
      end
    endcase
    return q;
  endfunction

endpackage

// ===== design/box_blur_3x3_rgb_core.sv =====
// streaming 3x3 rgb box blur with two line stores, window and output queue
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | in_command, in_red, in_green, in_blue
//   out_    | output    | out_valid / out_ready | out_red, out_green, out_blue, out_last_of_frame
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// one beat per cycle in while in_ready is high; results pass the window, sum and divide stages
// line stores are read on accept and written back in the cycle after, with forwarding
// an 8-entry output queue absorbs stalls; in_ready drops when queue plus pipeline is full
// synchronous active-low reset clears counters, valids and the window; line stores
// hold garbage until written, which only ever lands outside the frame
module box_blur_3x3_rgb_core
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [CHAN_W-1:0]   in_red,
  input  logic [CHAN_W-1:0]   in_green,
  input  logic [CHAN_W-1:0]   in_blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAN_W-1:0]   out_red,
  output logic [CHAN_W-1:0]   out_green,
  output logic [CHAN_W-1:0]   out_blue,
  output logic                out_last_of_frame,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

  // configuration, held as effective values
  logic [WW-1:0]       width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;

  // frame position
  logic [CW-1:0]       in_col_r, in_col_nxt;
  logic [ROW_W-1:0]    in_row_r, in_row_nxt;
  logic [CW-1:0]       out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic                started_r, started_nxt;

  // accept stage
  logic                go, act, feed, emit, frame_full;
  logic [WW-1:0]       in_col_inc, out_col_inc;
  logic [31:0]         cfg_w32;
  rgb_t                pix_in;
  geom_t               geom;

  // line stores
  rgb_t                older_row_r [MAX_WIDTH];
  rgb_t                newer_row_r [MAX_WIDTH];
  rgb_t                rd_old_r, rd_new_r;
  logic                fwd_r;
  rgb_t                fwd_old_r, fwd_new_r;

  // window stage
  logic                s1_v_r;
  logic                s1_emit_r;
  logic [CW-1:0]       s1_col_r;
  rgb_t                s1_pix_r;
  geom_t               s1_geom_r;
  rgb_t                top_v, mid_v;
  rgb_t                win_r [9];

  // sum stage
  logic                s2_v_r;
  geom_t               s2_geom_r;
  logic [2:0]          row_ok, col_ok;
  logic [SUM_W-1:0]    sum_r_c, sum_g_c, sum_b_c;
  div_t                div_c;

  // divide stage
  logic                s3_v_r;
  logic                s3_last_r;
  div_t                s3_div_r;
  logic [SUM_W-1:0]    s3_sum_r_r, s3_sum_g_r, s3_sum_b_r;
  out_item_t           res_item;

  // output queue
  out_item_t           fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                push, pop;
  logic [CREDIT_W-1:0] credit;

  // ---------------------------------------------------------------- accept

  assign credit = CREDIT_W'(cnt_r) + CREDIT_W'(s1_v_r) + CREDIT_W'(s2_v_r)
                + CREDIT_W'(s3_v_r);
  assign in_ready = credit < CREDIT_W'(FIFO_DEPTH);

  assign go         = in_valid && in_ready;
  assign frame_full = in_row_r >= ROW_W'(height_r);
  // early drain beats are taken and dropped
  assign act        = go && (!in_command || (started_r && frame_full));
  assign feed       = !in_command && !frame_full;
  assign pix_in     = feed ? rgb_t'({in_red, in_green, in_blue}) : rgb_t'('0);
  assign emit       = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);

  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);

  assign geom.top  = out_row_r == '0;
  assign geom.bot  = out_row_r >= height_r - HEIGHT_W'(1);
  assign geom.lft  = out_col_r == '0;
  assign geom.rgt  = WW'(out_col_r) >= width_r - WW'(1);
  assign geom.last = geom.bot && geom.rgt;

  assign cfg_w32 = 32'(cfg_wdata[FRAME_WIDTH_W-1:0]);

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    started_nxt = started_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_w32 < 32'd2) begin
            width_nxt = WW'(2);
          end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_w32);
          end
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = (cfg_wdata < CFG_W'(2)) ? HEIGHT_W'(2) : cfg_wdata;
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      started_nxt = 1'b0;
    end else if (act) begin
      if (feed) begin
        started_nxt = 1'b1;
      end
      if (in_col_inc >= width_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = CW'(in_col_inc);
      end
      if (emit) begin
        if (geom.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          started_nxt = 1'b0;
        end else if (out_col_inc >= width_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HEIGHT_W'(1);
        end else begin
          out_col_nxt = CW'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WW'(RESET_W);
      height_r  <= HEIGHT_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      started_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      started_r <= started_nxt;
    end
  end

  // ---------------------------------------------------------------- line stores

  // the entry written this cycle may be the one read by the new beat
  assign top_v = fwd_r ? fwd_old_r : rd_old_r;
  assign mid_v = fwd_r ? fwd_new_r : rd_new_r;

  always_ff @(posedge clk) begin
    if (act) begin
      rd_old_r  <= older_row_r[in_col_r];
      rd_new_r  <= newer_row_r[in_col_r];
      fwd_r     <= s1_v_r && (s1_col_r == in_col_r);
      fwd_old_r <= mid_v;
      fwd_new_r <= s1_pix_r;
      s1_col_r  <= in_col_r;
      s1_pix_r  <= pix_in;
      s1_emit_r <= emit;
      s1_geom_r <= geom;
    end
    if (s1_v_r) begin
      older_row_r[s1_col_r] <= mid_v;
      newer_row_r[s1_col_r] <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------- window

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_v;
      win_r[5] <= mid_v;
      win_r[8] <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------- sums

  assign row_ok = {!s2_geom_r.bot, 1'b1, !s2_geom_r.top};
  assign col_ok = {!s2_geom_r.rgt, 1'b1, !s2_geom_r.lft};

  always_comb begin
    sum_r_c = '0;
    sum_g_c = '0;
    sum_b_c = '0;
    for (int i = 0; i < 9; i++) begin
      if (row_ok[i/3] && col_ok[i%3]) begin
        sum_r_c = sum_r_c + SUM_W'(win_r[i].r);
        sum_g_c = sum_g_c + SUM_W'(win_r[i].g);
        sum_b_c = sum_b_c + SUM_W'(win_r[i].b);
      end
    end
    if ((s2_geom_r.top || s2_geom_r.bot) && (s2_geom_r.lft || s2_geom_r.rgt)) begin
      div_c = DIV4;
    end else if (s2_geom_r.top || s2_geom_r.bot || s2_geom_r.lft || s2_geom_r.rgt) begin
      div_c = DIV6;
    end else begin
      div_c = DIV9;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_geom_r <= s1_geom_r;
    end
    if (s2_v_r) begin
      s3_sum_r_r <= sum_r_c;
      s3_sum_g_r <= sum_g_c;
      s3_sum_b_r <= sum_b_c;
      s3_div_r   <= div_c;
      s3_last_r  <= s2_geom_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= act;
      s2_v_r <= s1_v_r && s1_emit_r;
      s3_v_r <= s2_v_r;
    end
  end

  // ---------------------------------------------------------------- divide

  assign res_item.pix.r = div_round(s3_sum_r_r, s3_div_r);
  assign res_item.pix.g = div_round(s3_sum_g_r, s3_div_r);
  assign res_item.pix.b = div_round(s3_sum_b_r, s3_div_r);
  assign res_item.last  = s3_last_r;

  // ---------------------------------------------------------------- output queue

  assign push      = s3_v_r;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;

  assign out_red           = fifo_r[rd_ptr_r].pix.r;
  assign out_green         = fifo_r[rd_ptr_r].pix.g;
  assign out_blue          = fifo_r[rd_ptr_r].pix.b;
  assign out_last_of_frame = fifo_r[rd_ptr_r].last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- checks

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < FIFO_CW'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue count out of range");

  a_sum_follows_window: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r && s1_emit_r))
    else $error("sum stage valid without a window update");

  a_store_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> WW'(s1_col_r) < width_r)
    else $error("line store access beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= ROW_W'(height_r) + ROW_W'(1))
    else $error("input row ran past the drain rows");
`endif

endmodule
